@@ src/nps_pkg.sv @@
`default_nettype none
package nps_pkg;

   // Command codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_REPLY
   } back_state_type;

   // Command queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int OPCODE_BITS   = 2;
   localparam int INDEX_BITS    = 8;
   localparam int RSP_DATA_BITS = 16;

endpackage
`default_nettype wire

@@ src/nearest_point_search.sv @@
// Channel | Direction | Ports                                      | Carries
// req     | in        | req_tvalid req_tready req_tdata req_tuser  | clear, append, query commands
// rsp     | out       | rsp_tvalid rsp_tready rsp_tdata            | one result per query
//
// Clear and append are done by the back in its idle state; a query runs a
// scan that reads one stored point a cycle from the point store and runs
// it through the distance pipeline. A two-entry command queue parts the
// front from the back, so up to two requests are still taken while the back
// scans or a result waits.
// Reset is synchronous and clears the entry count; store contents stay.
// A result held in the output register stalls the back until it is taken.
`default_nettype none
module nearest_point_search #(
   parameter int MAX_ENTRIES = 256,
   parameter int COORD_BITS  = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: pos_x, pos_y, pos_z, entry_present (lowest first), zero padded
   input  wire logic [((3*COORD_BITS+1+7)/8)*8-1:0] req_tdata,
   // tuser: opcode
   input  wire logic [nps_pkg::OPCODE_BITS-1:0]    req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // tdata: found, nearest_index (lowest first), zero padded
   output logic [nps_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   localparam int REQ_DATA_BITS = ((3 * COORD_BITS + 1 + 7) / 8) * 8;
   localparam int CMD_BITS      = 3 * COORD_BITS + 1 + nps_pkg::OPCODE_BITS;

   nps_pkg::queue_status_type q_status;
   logic                      push_valid;
   logic [CMD_BITS-1:0]       push_data;
   logic                      pop;
   logic [CMD_BITS-1:0]       head_data;

   nps_front #(
      .COORD_BITS    (COORD_BITS),
      .REQ_DATA_BITS (REQ_DATA_BITS),
      .CMD_BITS      (CMD_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   nps_cmd_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .status     (q_status)
   );

   nps_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COORD_BITS  (COORD_BITS),
      .CMD_BITS    (CMD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A known command taken from req must be waiting in the queue next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_tuser == nps_pkg::OP_CLEAR || req_tuser == nps_pkg::OP_APPEND ||
        req_tuser == nps_pkg::OP_QUERY)) |=> !q_status.empty)
      else $error("accepted command missing from queue");

   // The front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("push into full command queue");

   // A not-found result reports index zero
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[8:1] == 8'd0))
      else $error("not-found result with non-zero index");

endmodule
`default_nettype wire

@@ src/nps_front.sv @@
`default_nettype none
module nps_front #(
   parameter int COORD_BITS    = 24,
   parameter int REQ_DATA_BITS = ((3 * COORD_BITS + 1 + 7) / 8) * 8,
   parameter int CMD_BITS      = 3 * COORD_BITS + 1 + nps_pkg::OPCODE_BITS
) (
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]        req_tdata,
   input  wire logic [nps_pkg::OPCODE_BITS-1:0] req_tuser,
   input  wire nps_pkg::queue_status_type       q_status,
   output logic                                 push_valid,
   output logic [CMD_BITS-1:0]                  push_data
);

   logic known_op;

   // Classify the opcode: reserved codes are taken and dropped
   always_comb begin
      case (nps_pkg::opcode_type'(req_tuser))
         nps_pkg::OP_CLEAR,
         nps_pkg::OP_APPEND,
         nps_pkg::OP_QUERY: known_op = 1'b1;
         default:           known_op = 1'b0;
      endcase
   end

   // Accept whenever the queue has room; forward only known commands
   assign req_tready = !q_status.full;
   assign push_valid = req_tvalid && !q_status.full && known_op;
   assign push_data  = {req_tdata[3*COORD_BITS:0], req_tuser};

endmodule
`default_nettype wire

@@ src/nps_cmd_queue.sv @@
`default_nettype none
module nps_cmd_queue #(
   parameter int WIDTH = 75
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   input  wire logic [WIDTH-1:0]          push_data,
   input  wire logic                      pop,
   output logic [WIDTH-1:0]               head_data,
   output nps_pkg::queue_status_type      status
);

   logic [WIDTH-1:0] entries_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push_fire, pop_fire;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign push_fire    = push_valid && !status.full;
   assign pop_fire     = pop && !status.empty;
   assign head_data    = entries_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push_fire ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_fire ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push_fire} - {1'b0, pop_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ src/nps_back.sv @@
`default_nettype none
module nps_back #(
   parameter int MAX_ENTRIES = 256,
   parameter int COORD_BITS  = 24,
   parameter int CMD_BITS    = 3 * COORD_BITS + 1 + nps_pkg::OPCODE_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [CMD_BITS-1:0]               head_data,
   input  wire nps_pkg::queue_status_type         q_status,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [nps_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);

   localparam int AW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW        = $clog2(MAX_ENTRIES + 1);
   localparam int EW        = 3 * COORD_BITS + 1;
   localparam int DW        = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * COORD_BITS + 2;
   localparam int DIST_BITS = 2 * COORD_BITS + 4;
   localparam int OB        = nps_pkg::OPCODE_BITS;

   function automatic logic [DW-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b);
      logic [DW-1:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return d[DW-1] ? (~d + DW'(1)) : d;
   endfunction

   // Point store
   logic [EW-1:0] mem [MAX_ENTRIES];

   nps_pkg::back_state_type state_ff, state_in;
   nps_pkg::opcode_type     head_op;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           scan_addr_ff;
   logic                    wr_en, load_query, scan_issue, reply;

   logic [COORD_BITS-1:0]   qx_ff, qy_ff, qz_ff;
   logic [EW-1:0]           rd_ff;
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0]           idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [DW-1:0]           dx2_ff, dy2_ff, dz2_ff;
   logic [SQ_BITS-1:0]      sqx3_ff, sqy3_ff, sqz3_ff;
   logic [DIST_BITS-1:0]    dist4_ff;
   logic                    have_ff;
   logic [DIST_BITS-1:0]    best_dist_ff;
   logic [AW-1:0]           best_idx_ff;
   logic                    take;
   logic [31:0]             best_idx_wide;

   logic                                 rsp_valid_ff;
   logic [nps_pkg::RSP_DATA_BITS-1:0]    rsp_data_ff;

   assign head_op = nps_pkg::opcode_type'(head_data[OB-1:0]);

   // Sequence commands from the queue head
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pop        = 1'b0;
      wr_en      = 1'b0;
      load_query = 1'b0;
      scan_issue = 1'b0;
      reply      = 1'b0;
      case (state_ff)
         nps_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               case (head_op)
                  nps_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  nps_pkg::OP_APPEND: begin
                     if (count_ff < CW'(MAX_ENTRIES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  nps_pkg::OP_QUERY: begin
                     load_query = 1'b1;
                     state_in   = (count_ff == '0) ? nps_pkg::BK_REPLY : nps_pkg::BK_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         nps_pkg::BK_SCAN: begin
            scan_issue = 1'b1;
            if (CW'(scan_addr_ff) + CW'(1) == count_ff) begin
               state_in = nps_pkg::BK_DRAIN;
            end
         end
         nps_pkg::BK_DRAIN: begin
            if (!(v1_ff || v2_ff || v3_ff || v4_ff)) begin
               state_in = nps_pkg::BK_REPLY;
            end
         end
         nps_pkg::BK_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               reply    = 1'b1;
               state_in = nps_pkg::BK_IDLE;
            end
         end
         default: state_in = nps_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nps_pkg::BK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Write on append, read the scan address every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= head_data[OB +: EW];
      end
      rd_ff <= mem[scan_addr_ff];
   end

   // Latch the query point and step the scan address
   always_ff @(posedge clock) begin
      if (load_query) begin
         qx_ff        <= head_data[OB +: COORD_BITS];
         qy_ff        <= head_data[OB + COORD_BITS +: COORD_BITS];
         qz_ff        <= head_data[OB + 2 * COORD_BITS +: COORD_BITS];
         scan_addr_ff <= '0;
      end else if (scan_issue) begin
         scan_addr_ff <= scan_addr_ff + AW'(1);
      end
   end

   // Distance pipeline: read, difference, square, sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= scan_issue;
         v2_ff <= v1_ff && rd_ff[EW-1];
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= scan_addr_ff;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      idx4_ff  <= idx3_ff;
      dx2_ff   <= abs_diff(qx_ff, rd_ff[0 +: COORD_BITS]);
      dy2_ff   <= abs_diff(qy_ff, rd_ff[COORD_BITS +: COORD_BITS]);
      dz2_ff   <= abs_diff(qz_ff, rd_ff[2 * COORD_BITS +: COORD_BITS]);
      sqx3_ff  <= SQ_BITS'(dx2_ff) * SQ_BITS'(dx2_ff);
      sqy3_ff  <= SQ_BITS'(dy2_ff) * SQ_BITS'(dy2_ff);
      sqz3_ff  <= SQ_BITS'(dz2_ff) * SQ_BITS'(dz2_ff);
      dist4_ff <= DIST_BITS'(sqx3_ff) + DIST_BITS'(sqy3_ff) + DIST_BITS'(sqz3_ff);
   end

   // Keep the first strictly smaller distance
   assign take = v4_ff && (!have_ff || (dist4_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff     <= 1'b0;
         best_idx_ff <= '0;
      end else if (load_query) begin
         have_ff     <= 1'b0;
         best_idx_ff <= '0;
      end else if (take) begin
         have_ff     <= 1'b1;
         best_idx_ff <= idx4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff <= dist4_ff;
      end
   end

   // Hold the result until the downstream side takes it
   assign best_idx_wide = 32'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reply) begin
         rsp_data_ff <= {7'd0, best_idx_wide[nps_pkg::INDEX_BITS-1:0], have_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
